[design/rsti_pkg.sv]
// Package for the radix string to integer block: codes, reset values,
// token and result types shared by the front, back and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsti_pkg;

  localparam int CHAR_W      = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int RADIX_W     = 5;
  localparam int DIG_W       = 4;
  localparam int ALPHA_CHARS = 16;
  localparam int OUT_W       = 32;

  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN = 2'd2;

  // decimal alphabet "0123456789"
  localparam logic [CFG_W-1:0]   ALPHA_LO_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   ALPHA_HI_RST  = 64'h0000_0000_0000_3938;
  localparam logic [RADIX_W-1:0] ALPHA_LEN_RST = 5'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  // one classified character, as passed from front to back
  typedef struct packed {
    logic               nul;
    logic               ws;
    logic               plus;
    logic               minus;
    logic               dig_ok;
    logic [DIG_W-1:0]   dig;
    logic [RADIX_W-1:0] radix;
    logic               bad;
  } token_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             alphabet_invalid;
  } res_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

endpackage
`default_nettype wire

[design/rsti_fifo.sv]
// Small register queue with a registered store, used between the front
// and back and again for results. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module rsti_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/rsti_front.sv]
// Front end: alphabet registers, alphabet check and character classing.
// Depends on rsti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsti_front #(
  parameter int MAX_RADIX = rsti_pkg::MAX_RADIX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rsti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsti_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [rsti_pkg::CHAR_W-1:0]    char_code,
  output rsti_pkg::token_t                   tok
);

  localparam int RW = rsti_pkg::RADIX_W;

  logic [rsti_pkg::CFG_W-1:0]  alpha_lo;
  logic [rsti_pkg::CFG_W-1:0]  alpha_hi;
  logic [RW-1:0]               alpha_len;

  logic [rsti_pkg::CHAR_W-1:0] chars [rsti_pkg::ALPHA_CHARS];
  logic [RW-1:0]               radix;
  logic                        bad;
  logic                        dig_ok;
  logic [rsti_pkg::DIG_W-1:0]  dig;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_lo  <= rsti_pkg::ALPHA_LO_RST;
      alpha_hi  <= rsti_pkg::ALPHA_HI_RST;
      alpha_len <= rsti_pkg::ALPHA_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsti_pkg::CFG_ALPHA_LO:  alpha_lo  <= cfg_data;
        rsti_pkg::CFG_ALPHA_HI:  alpha_hi  <= cfg_data;
        rsti_pkg::CFG_ALPHA_LEN: alpha_len <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      chars[k]     = alpha_lo[8*k +: 8];
      chars[k + 8] = alpha_hi[8*k +: 8];
    end
  end

  assign radix = (alpha_len > RW'(MAX_RADIX)) ? RW'(MAX_RADIX) : alpha_len;

  // any illegal character or any repeat among the characters in use
  always_comb begin
    bad = (radix <= RW'(1));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RW'(i) < radix) begin
        if (chars[i] == rsti_pkg::CH_NUL || chars[i] == rsti_pkg::CH_PLUS ||
            chars[i] == rsti_pkg::CH_MINUS || rsti_pkg::is_ws(chars[i])) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RW'(j) < radix && chars[j] == chars[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  // scan from the top so the lowest matching position wins
  always_comb begin
    dig_ok = 1'b0;
    dig    = '0;
    for (int i = MAX_RADIX - 1; i >= 0; i--) begin
      if (RW'(i) < radix && chars[i] == char_code) begin
        dig_ok = 1'b1;
        dig    = rsti_pkg::DIG_W'(i);
      end
    end
  end

  always_comb begin
    tok.nul    = (char_code == rsti_pkg::CH_NUL);
    tok.ws     = rsti_pkg::is_ws(char_code);
    tok.plus   = (char_code == rsti_pkg::CH_PLUS);
    tok.minus  = (char_code == rsti_pkg::CH_MINUS);
    tok.dig_ok = dig_ok;
    tok.dig    = dig;
    tok.radix  = radix;
    tok.bad    = bad;
  end

endmodule
`default_nettype wire

[design/rsti_back.sv]
// Back end: parse state machine, sign and multiply-add accumulator.
// Depends on rsti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsti_back #(
  parameter int VALUE_BITS = rsti_pkg::VALUE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rsti_pkg::token_t tok,
  input  wire logic             tok_empty,
  input  wire logic             res_full,
  output logic                  tok_pop,
  output logic                  res_push,
  output rsti_pkg::res_t        res
);

  localparam int RW = rsti_pkg::RADIX_W;
  localparam int OW = rsti_pkg::OUT_W;

  rsti_pkg::phase_t phase;
  rsti_pkg::phase_t phase_next;
  logic                  negative;
  logic                  negative_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;

  logic                     reach_sign;
  logic                     reach_digit;
  logic                     is_sign;
  logic [VALUE_BITS+RW-1:0] prod;
  logic [VALUE_BITS-1:0]    signed_acc;
  logic [OW-1:0]            v32;

  // a NUL waits for room in the result queue, other characters never stall
  assign tok_pop  = !tok_empty && (!tok.nul || !res_full);
  assign res_push = tok_pop && tok.nul;
  assign is_sign  = tok.plus || tok.minus;

  // which phases this character falls through
  always_comb begin
    reach_sign  = 1'b0;
    reach_digit = 1'b0;
    unique case (phase)
      rsti_pkg::PH_SPACE: begin
        reach_sign  = !tok.ws;
        reach_digit = !tok.ws && !is_sign;
      end
      rsti_pkg::PH_SIGN: begin
        reach_sign  = 1'b1;
        reach_digit = !is_sign;
      end
      rsti_pkg::PH_DIGIT: reach_digit = 1'b1;
      rsti_pkg::PH_SKIP:  ;
      default: ;
    endcase
  end

  always_comb begin
    if (tok.nul) begin
      phase_next = rsti_pkg::PH_SPACE;
    end else if (reach_digit) begin
      phase_next = tok.dig_ok ? rsti_pkg::PH_DIGIT : rsti_pkg::PH_SKIP;
    end else if (reach_sign) begin
      phase_next = rsti_pkg::PH_SIGN;
    end else begin
      phase_next = phase;
    end
  end

  assign prod = {{RW{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, tok.radix};

  always_comb begin
    negative_next = negative;
    acc_next      = acc;
    if (tok.nul) begin
      negative_next = 1'b0;
      acc_next      = '0;
    end else begin
      if (reach_sign && !reach_digit && tok.minus) begin
        negative_next = !negative;
      end
      if (reach_digit && tok.dig_ok) begin
        acc_next = prod[VALUE_BITS-1:0] +
                   {{(VALUE_BITS - rsti_pkg::DIG_W){1'b0}}, tok.dig};
      end
    end
  end

  assign signed_acc = negative ? (~acc + 1'b1) : acc;

  generate
    if (VALUE_BITS >= OW) begin : g_trunc
      assign v32 = signed_acc[OW-1:0];
    end else begin : g_ext
      assign v32 = {{(OW - VALUE_BITS){1'b0}}, signed_acc};
    end
  endgenerate

  always_comb begin
    res.value            = tok.bad ? '0 : v32;
    res.alphabet_invalid = tok.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= rsti_pkg::PH_SPACE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (tok_pop) begin
      phase    <= phase_next;
      negative <= negative_next;
      acc      <= acc_next;
    end
  end

endmodule
`default_nettype wire

[design/radix_string_to_integer.sv]
// Top level of the radix string to integer block: front, token queue,
// back and result queue. Depends on rsti_pkg, rsti_front, rsti_back, rsti_fifo.
//
//   channel   handshake       payload                     notes
//   input     push / full     char_code[7:0]              one character per transfer
//   result    empty / pop     value[31:0], alphabet_invalid  one per NUL
//   config    cfg_we          cfg_index[1:0], cfg_data[63:0] no wait, no read-back
//
// One character per cycle sustained while the back end does not stall; its single
// multiply-add on the accumulator sets that figure. A result reaches the result
// ports once its NUL has passed through the token queue, the back end and the
// result queue. Reset (rst, synchronous) empties both queues, clears the parse
// state and loads the decimal alphabet. full rises once the two-entry token queue
// holds two; the back end stalls only on a NUL while the result queue is full.
`timescale 1ns / 1ps
`default_nettype none
module radix_string_to_integer #(
  parameter int MAX_RADIX  = rsti_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = rsti_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [rsti_pkg::CHAR_W-1:0]    char_code,
  output logic                                empty,
  input  wire logic                           pop,
  output logic signed [rsti_pkg::OUT_W-1:0]   value,
  output logic                                alphabet_invalid,
  input  wire logic                           cfg_we,
  input  wire logic [rsti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsti_pkg::CFG_W-1:0]     cfg_data
);

  localparam int TOK_W = $bits(rsti_pkg::token_t);
  localparam int RES_W = $bits(rsti_pkg::res_t);

  rsti_pkg::token_t tok_in;
  rsti_pkg::token_t tok_out;
  rsti_pkg::res_t   res_in;
  rsti_pkg::res_t   res_out;
  logic             tok_empty;
  logic             tok_pop;
  logic             res_full;
  logic             res_push;

  rsti_front #(.MAX_RADIX(MAX_RADIX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_code (char_code),
    .tok       (tok_in)
  );

  rsti_fifo #(.WIDTH(TOK_W), .DEPTH(2)) u_tok_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (tok_in),
    .pop   (tok_pop),
    .rdata (tok_out),
    .full  (full),
    .empty (tok_empty)
  );

  rsti_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok_out),
    .tok_empty (tok_empty),
    .res_full  (res_full),
    .tok_pop   (tok_pop),
    .res_push  (res_push),
    .res       (res_in)
  );

  rsti_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (empty)
  );

  assign value            = res_out.value;
  assign alphabet_invalid = res_out.alphabet_invalid;

endmodule
`default_nettype wire

[design/rsti_checker.sv]
// Port-level checks for radix_string_to_integer, bound to the top level.
// Depends on rsti_pkg and radix_string_to_integer.
`timescale 1ns / 1ps
`default_nettype none
module rsti_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           full,
  input wire logic                           empty,
  input wire logic                           pop,
  input wire logic [rsti_pkg::OUT_W-1:0]     value,
  input wire logic                           alphabet_invalid
);

  // reset leaves both sides with nothing queued
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  // a bad alphabet always forces the value to zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && alphabet_invalid) |-> (value == '0))
    else $error("nonzero value with invalid alphabet");

  // a waiting result holds until its transfer
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(alphabet_invalid)))
    else $error("result changed before transfer");

endmodule

bind radix_string_to_integer rsti_checker u_rsti_checker (
  .clk              (clk),
  .rst              (rst),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .value            (value),
  .alphabet_invalid (alphabet_invalid)
);
`default_nettype wire
